// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, switched off while rst is high.
`define PPMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion sampled on clk that also holds through reset.
`define PPMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ppmp_pkg.sv
// ----------------------------------------------------------------------------
// ppmp_pkg
// Types, codes and sizes shared by the packed-pixel plotter modules.
// ----------------------------------------------------------------------------
package ppmp_pkg;

  localparam int SCREEN_WIDTH_DEF  = 832;
  localparam int SCREEN_HEIGHT_DEF = 624;
  localparam int STORE_WORDS_DEF   = 524288;

  // Word index of a pixel: an 11-bit row times a 12-bit stride plus an 11-bit offset.
  localparam int IDX_W       = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [0:0] REG_DEPTH  = 1'd0;
  localparam logic [0:0] REG_STRIDE = 1'd1;

  localparam logic       REQ_PLOT = 1'b0;
  localparam logic       REQ_READ = 1'b1;

  localparam logic [1:0] OP_BLACK  = 2'd0;
  localparam logic [1:0] OP_WHITE  = 2'd1;
  localparam logic [1:0] OP_INVERT = 2'd2;
  localparam logic [1:0] OP_BAD    = 2'd3;

  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_2  = 3'd1;
  localparam logic [2:0] DEPTH_4  = 3'd2;
  localparam logic [2:0] DEPTH_8  = 3'd3;
  localparam logic [2:0] DEPTH_16 = 3'd4;
  localparam logic [2:0] DEPTH_32 = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_OFF   = 2'd1;
  localparam logic [1:0] ST_BADOP = 2'd2;

  localparam logic [11:0] STRIDE_RESET = 12'd26;

  typedef struct packed {
    logic [1:0]       status;
    logic             is_read;
    logic [1:0]       op;
    logic             wide;
    logic             access;
    logic [31:0]      mask;
    logic [IDX_W-1:0] word_idx;
  } ppmp_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic       read_black;
  } ppmp_res_t;

endpackage

// File: hw/rtl/ppmp_queue.sv
// ----------------------------------------------------------------------------
// ppmp_queue
// Small first-in first-out queue of registers with a count.
// ----------------------------------------------------------------------------
module ppmp_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     data [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = data[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      data[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/ppmp_front.sv
// ----------------------------------------------------------------------------
// ppmp_front
// Classifies each request, works out word index and lane mask, and queues it.
// ----------------------------------------------------------------------------
module ppmp_front
  import ppmp_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int STORE_WORDS   = STORE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              hold,
  output logic              full,
  input  logic              req_type,
  input  logic signed [11:0] pixel_x,
  input  logic signed [11:0] pixel_y,
  input  logic [1:0]        draw_op,
  input  logic [2:0]        depth_mode,
  input  logic [11:0]       line_stride_words,
  input  logic              cmd_pop,
  output ppmp_cmd_t         cmd,
  output logic              cmd_empty
);

  logic             q_full;
  logic             off_screen;
  logic             bad_op;
  logic             depth_ok;
  logic [10:0]      ux;
  logic [10:0]      xw;
  logic [1:0]       lane;
  logic [7:0]       m8;
  logic [31:0]      mask;
  logic [22:0]      row_base;
  logic [IDX_W-1:0] word_idx;
  ppmp_cmd_t        new_cmd;

  assign full = q_full || hold;
  assign ux   = pixel_x[10:0];

  assign off_screen = pixel_x[11] || pixel_y[11]
                   || ($unsigned(pixel_x) >= 12'(SCREEN_WIDTH))
                   || ($unsigned(pixel_y) >= 12'(SCREEN_HEIGHT));
  assign bad_op   = (req_type == REQ_PLOT) && (draw_op == OP_BAD);
  assign depth_ok = (depth_mode <= DEPTH_32);

  always_comb begin
    xw   = ux;
    lane = 2'd0;
    m8   = 8'hFF;
    mask = 32'hFFFF_FFFF;
    unique case (depth_mode)
      DEPTH_1: begin
        xw   = ux >> 5;
        lane = ux[4:3];
        m8   = 8'h80 >> ux[2:0];
      end
      DEPTH_2: begin
        xw   = ux >> 4;
        lane = ux[3:2];
        m8   = 8'hC0 >> {ux[1:0], 1'b0};
      end
      DEPTH_4: begin
        xw   = ux >> 3;
        lane = ux[2:1];
        m8   = 8'hF0 >> {ux[0], 2'b00};
      end
      DEPTH_8: begin
        xw   = ux >> 2;
        lane = ux[1:0];
      end
      DEPTH_16: begin
        xw = ux >> 1;
      end
      default: begin
        xw = ux;
      end
    endcase
    if (depth_mode <= DEPTH_8) begin
      // Byte lane zero is the most significant byte of the word.
      mask = 32'(m8) << {~lane, 3'b000};
    end else if (depth_mode == DEPTH_16) begin
      mask = ux[0] ? 32'h0000_FFFF : 32'hFFFF_0000;
    end
  end

  assign row_base = pixel_y[10:0] * line_stride_words;
  assign word_idx = IDX_W'(row_base) + IDX_W'(xw);

  always_comb begin
    new_cmd.status   = off_screen ? ST_OFF : (bad_op ? ST_BADOP : ST_DONE);
    new_cmd.is_read  = req_type;
    new_cmd.op       = draw_op;
    new_cmd.wide     = (depth_mode >= DEPTH_16);
    new_cmd.access   = !off_screen && !bad_op && depth_ok
                    && (word_idx < IDX_W'(STORE_WORDS));
    new_cmd.mask     = mask;
    new_cmd.word_idx = word_idx;
  end

  ppmp_queue #(
    .W     ($bits(ppmp_cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !hold),
    .wr_data (new_cmd),
    .rd_en   (cmd_pop),
    .rd_data (cmd),
    .full    (q_full),
    .empty   (cmd_empty)
  );

endmodule

// File: hw/rtl/ppmp_back.sv
// ----------------------------------------------------------------------------
// ppmp_back
// Owns the frame store: clears it after reset, then runs each queued request
// as a read followed, for a plot, by a write, and queues the result.
// ----------------------------------------------------------------------------
module ppmp_back
  import ppmp_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  ppmp_cmd_t  cmd,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  output logic       clearing,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] status,
  output logic       read_black
);

  localparam int ADDR_W = $clog2(STORE_WORDS);

  logic [31:0]       store [STORE_WORDS];
  logic [31:0]       rdata;
  logic [ADDR_W-1:0] clr_addr;
  logic              busy;
  ppmp_cmd_t         cur;
  logic              res_full;
  logic [31:0]       new_word;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  ppmp_res_t         res;
  ppmp_res_t         res_out;

  // No request is taken while busy holds the last one, so a write always lands
  // before the next read of the store.
  assign cmd_pop = !cmd_empty && !busy && !res_full && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      busy     <= 1'b0;
    end else begin
      if (clearing && (clr_addr == ADDR_W'(STORE_WORDS - 1))) begin
        clearing <= 1'b0;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      busy <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur   <= cmd;
      rdata <= store[cmd.word_idx[ADDR_W-1:0]];
    end
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    priority if (cur.op == OP_INVERT) begin
      new_word = rdata ^ cur.mask;
    end else if ((cur.op == OP_BLACK) != cur.wide) begin
      new_word = rdata | cur.mask;
    end else begin
      new_word = rdata & ~cur.mask;
    end
  end

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = busy && cur.access && (cur.is_read == REQ_PLOT);
      wr_addr = cur.word_idx[ADDR_W-1:0];
      wr_data = new_word;
    end
  end

  assign res.status     = cur.status;
  assign res.read_black = cur.access && (cur.is_read == REQ_READ)
                       && ((rdata & cur.mask) != '0);

  ppmp_queue #(
    .W     ($bits(ppmp_res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (busy),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (res_out),
    .full    (res_full),
    .empty   (empty)
  );

  assign status     = res_out.status;
  assign read_black = res_out.read_black;

endmodule

// File: hw/rtl/packed_pixel_mono_plotter_core.sv
// A request passes through the command queue, the read stage (cur, rdata) and the result queue to the result ports.
// The back end takes no new request while the last one is busy, so the store's read then write never overlap.
// Reset: rst clears the queues and loads depth 1 bpp and a stride of 26 words.
// After reset a clearing pass zeroes the store one word a cycle, all STORE_WORDS
// words (524288 by default); full stays high until it ends.
// ----------------------------------------------------------------------------
// packed_pixel_mono_plotter_core
// Top level: configuration registers, request front end and store back end.
// ----------------------------------------------------------------------------
module packed_pixel_mono_plotter_core
  import ppmp_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int STORE_WORDS   = STORE_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic               req_type,
  input  logic signed [11:0] pixel_x,
  input  logic signed [11:0] pixel_y,
  input  logic [1:0]         draw_op,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status,
  output logic               read_black
);

  logic [2:0]  depth_mode;
  logic [11:0] line_stride_words;
  ppmp_cmd_t   cmd;
  logic        cmd_empty;
  logic        cmd_pop;
  logic        clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode        <= DEPTH_1;
      line_stride_words <= STRIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH:  depth_mode        <= cfg_data[2:0];
        REG_STRIDE: line_stride_words <= cfg_data;
        default: ;
      endcase
    end
  end

  ppmp_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .STORE_WORDS   (STORE_WORDS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .hold              (clearing),
    .full              (full),
    .req_type          (req_type),
    .pixel_x           (pixel_x),
    .pixel_y           (pixel_y),
    .draw_op           (draw_op),
    .depth_mode        (depth_mode),
    .line_stride_words (line_stride_words),
    .cmd_pop           (cmd_pop),
    .cmd               (cmd),
    .cmd_empty         (cmd_empty)
  );

  ppmp_back #(
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .clearing   (clearing),
    .pop        (pop),
    .empty      (empty),
    .status     (status),
    .read_black (read_black)
  );

endmodule

// File: hw/rtl/ppmp_checker.sv
// ----------------------------------------------------------------------------
// ppmp_checker
// Port-level checks on the plotter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppmp_checker
  import ppmp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic [1:0] status,
  input logic       read_black
);

  // The store is being cleared straight after reset, so no request is taken.
  `PPMP_ASSERT_ALWAYS(a_full_after_rst, rst |=> full, "full low right after reset")
  // Nothing waits on the result side just after reset.
  `PPMP_ASSERT_ALWAYS(a_empty_after_rst, rst |=> empty, "result waiting after reset")
  `PPMP_ASSERT(a_status_code, !empty |-> (status == ST_DONE || status == ST_OFF || status == ST_BADOP), "undefined status code")
  // Only a completed request can report a black pixel.
  `PPMP_ASSERT(a_black_done, (!empty && read_black) |-> (status == ST_DONE), "read_black set on a failed request")

endmodule

bind packed_pixel_mono_plotter_core ppmp_checker u_ppmp_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .status     (status),
  .read_black (read_black)
);
